### rtl/core/sorted_insert_priority_queue_macros.svh
// Assertion macros for the sorted insert priority queue.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is low.
`define SIPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define SIPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SIPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SIPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### rtl/core/sipq_pkg.sv
// Shared types and constants of the sorted insert priority queue.
package sipq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 32;
    localparam int TAG_W = 16;
    localparam int IN_DATA_W = ((KEY_W + TAG_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((KEY_W + TAG_W + CNT_W + 7) / 8) * 8;

    // Input kind carried on tuser
    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_POP    = 1'b1
    } t_mode;

    // Result status carried on tuser
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Operation broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

endpackage

### rtl/core/sipq_cell.sv
// One storage cell of the sorted chain: holds a key and tag, shifts on insert or pop.
module sipq_cell (
    input  logic                      i_clk,
    input  sipq_pkg::t_cell_ctl       i_ctl,
    input  logic                      i_occ,       // this cell holds a live entry
    input  logic [sipq_pkg::KEY_W-1:0] i_new_key,
    input  logic [sipq_pkg::TAG_W-1:0] i_new_tag,
    input  logic                      i_prev_lt,   // left neighbor stays put on insert
    input  logic [sipq_pkg::KEY_W-1:0] i_prev_key,
    input  logic [sipq_pkg::TAG_W-1:0] i_prev_tag,
    input  logic [sipq_pkg::KEY_W-1:0] i_next_key,
    input  logic [sipq_pkg::TAG_W-1:0] i_next_tag,
    output logic                      o_lt,
    output logic [sipq_pkg::KEY_W-1:0] o_key,
    output logic [sipq_pkg::TAG_W-1:0] o_tag
);
    import sipq_pkg::*;

    logic [KEY_W-1:0] r_key, n_key;
    logic [TAG_W-1:0] r_tag, n_tag;
    logic             w_lt;

    // Stored key is strictly smaller: the new entry lands further right
    assign w_lt = i_occ && (r_key < i_new_key);

    // Next content: keep, take new entry, shift right, or shift left
    always_comb begin
        n_key = r_key;
        n_tag = r_tag;
        if (i_ctl.ins) begin
            if (!i_prev_lt) begin
                n_key = i_prev_key;
                n_tag = i_prev_tag;
            end else if (!w_lt) begin
                n_key = i_new_key;
                n_tag = i_new_tag;
            end
        end else if (i_ctl.pop) begin
            n_key = i_next_key;
            n_tag = i_next_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_lt  = w_lt;
    assign o_key = r_key;
    assign o_tag = r_tag;

endmodule

### rtl/core/sorted_insert_priority_queue.sv
// Sorted insert priority queue: a chain of key/tag cells kept in ascending key order.
//
// Input stream (s side): tuser = mode (0 insert, 1 pop), tdata = key, tag.
// Output stream (m side): tuser = status, tdata = out_key, out_tag, occupancy.
// Every accepted input gives exactly one result transfer.
// An insert goes ahead of the first stored entry with a key greater or equal;
// a pop returns the head (smallest key). Pop on empty reports status 2 and
// insert into a full queue is dropped with status 3.
// The result is registered and appears in the cycle after the input transfer.
// Throughput: one item per cycle while the receiver does not stall; each cell
// compares its key against the new key in parallel and all cells shift together,
// so the compare-and-shift across the chain sets the rate.
// Reset (synchronous, active low) empties the queue and drops any pending
// result. Cell contents are not cleared; only entries below the count are read.
// When the receiver stalls, the result stays in the output register and
// o_s_tready drops until the result is taken.
`include "sorted_insert_priority_queue_macros.svh"

module sorted_insert_priority_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [sipq_pkg::IN_DATA_W-1:0]  i_s_tdata,   // [31:0] key, [47:32] tag
    input  logic                            i_s_tuser,   // [0] mode
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [sipq_pkg::OUT_DATA_W-1:0] o_m_tdata,   // out_key, out_tag, occupancy, zero pad
    output logic [1:0]                      o_m_tuser    // [1:0] status
);
    import sipq_pkg::*;

    logic             w_in_acc;
    logic [KEY_W-1:0] w_new_key;
    logic [TAG_W-1:0] w_new_tag;
    t_mode            w_mode;
    t_cell_ctl        w_ctl;
    logic             w_full, w_empty;

    logic             w_lt  [DEPTH];
    logic [KEY_W-1:0] w_key [DEPTH];
    logic [TAG_W-1:0] w_tag [DEPTH];

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    t_status          r_status, n_status;
    logic [KEY_W-1:0] r_out_key, n_out_key;
    logic [TAG_W-1:0] r_out_tag, n_out_tag;
    logic [CNT_W-1:0] r_out_occ;

    // Input decode
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_new_key  = i_s_tdata[KEY_W-1:0];
    assign w_new_tag  = i_s_tdata[KEY_W+TAG_W-1:KEY_W];
    assign w_mode     = t_mode'(i_s_tuser);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    // Operation, status and new count
    always_comb begin
        w_ctl     = '0;
        n_count   = r_count;
        n_status  = ST_INSERTED;
        n_out_key = '0;
        n_out_tag = '0;
        case (w_mode)
            MODE_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.ins = w_in_acc;
                    n_count   = r_count + CNT_W'(1);
                    n_status  = ST_INSERTED;
                end
            end
            MODE_POP: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctl.pop = w_in_acc;
                    n_count   = r_count - CNT_W'(1);
                    n_status  = ST_POPPED;
                    n_out_key = w_key[0];
                    n_out_tag = w_tag[0];
                end
            end
            default: begin
                n_status = ST_INSERTED;
            end
        endcase
    end

    // Cell chain
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic             w_prev_lt;
        logic [KEY_W-1:0] w_prev_key, w_next_key;
        logic [TAG_W-1:0] w_prev_tag, w_next_tag;

        if (gi == 0) begin : g_head
            assign w_prev_lt  = 1'b1;
            assign w_prev_key = w_new_key;
            assign w_prev_tag = w_new_tag;
        end else begin : g_body
            assign w_prev_lt  = w_lt[gi-1];
            assign w_prev_key = w_key[gi-1];
            assign w_prev_tag = w_tag[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_next_key = '0;
            assign w_next_tag = '0;
        end else begin : g_link
            assign w_next_key = w_key[gi+1];
            assign w_next_tag = w_tag[gi+1];
        end

        sipq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occ      (CNT_W'(gi) < r_count),
            .i_new_key  (w_new_key),
            .i_new_tag  (w_new_tag),
            .i_prev_lt  (w_prev_lt),
            .i_prev_key (w_prev_key),
            .i_prev_tag (w_prev_tag),
            .i_next_key (w_next_key),
            .i_next_tag (w_next_tag),
            .o_lt       (w_lt[gi]),
            .o_key      (w_key[gi]),
            .o_tag      (w_tag[gi])
        );
    end

    // Count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_status  <= n_status;
            r_out_key <= n_out_key;
            r_out_tag <= n_out_tag;
            r_out_occ <= n_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = OUT_DATA_W'({r_out_occ, r_out_tag, r_out_key});

    // Checks
    `SIPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "count above depth")
    `SIPQ_ASSERT(a_empty_pop, i_clk, i_rst_n, w_in_acc && (w_mode == MODE_POP) && w_empty |=> o_m_tvalid && (o_m_tuser == ST_EMPTY), "pop on empty not reported")
    `SIPQ_ASSERT(a_occ_match, i_clk, i_rst_n, o_m_tvalid |-> (r_out_occ == r_count), "occupancy differs from count")
    `SIPQ_ASSERT(a_head_order, i_clk, i_rst_n, (r_count >= CNT_W'(2)) |-> (w_key[0] <= w_key[1]), "head entries out of order")
    `SIPQ_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_m_tvalid && (r_count == '0), "reset did not clear queue")

endmodule

### tb/sv/sorted_insert_priority_queue_tb.sv
// Self-checking testbench for the sorted insert priority queue.
`timescale 1ns / 1ps

module sorted_insert_priority_queue_tb;
    import sipq_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    // One result of the queue, unpacked from tuser/tdata
    typedef struct packed {
        t_status            status;
        logic [KEY_W-1:0]   key;
        logic [TAG_W-1:0]   tag;
        logic [CNT_W-1:0]   occupancy;
    } t_queue_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    // Shadow copy of the queue contents
    logic [KEY_W-1:0] shadow_keys [DEPTH];
    logic [TAG_W-1:0] shadow_tags [DEPTH];
    int               shadow_count = 0;

    t_queue_result pending_results [$];
    int            error_count = 0;
    int            cycle_count = 0;
    int            src_gap_max = 5;
    int            sink_gap_max = 5;
    int            sink_hold = 0;

    sorted_insert_priority_queue dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // [31:0] key, [47:32] tag
        .i_s_tuser  (s_tuser),   // [0] mode
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // [31:0] out_key, [47:32] out_tag, [52:48] occupancy
        .o_m_tuser  (m_tuser)    // [1:0] status
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Apply one operation to the shadow queue and return the result it gives
    function automatic t_queue_result queue_step(t_mode mode, logic [KEY_W-1:0] key,
                                                 logic [TAG_W-1:0] tag);
        t_queue_result res;
        int slot;
        res.status    = ST_INSERTED;
        res.key       = '0;
        res.tag       = '0;
        if (mode == MODE_INSERT) begin
            if (shadow_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // new entry goes ahead of the first key that is >= it
                slot = 0;
                while (slot < shadow_count && shadow_keys[slot] < key)
                    slot++;
                for (int i = shadow_count; i > slot; i--) begin
                    shadow_keys[i] = shadow_keys[i-1];
                    shadow_tags[i] = shadow_tags[i-1];
                end
                shadow_keys[slot] = key;
                shadow_tags[slot] = tag;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.status = ST_POPPED;
                res.key    = shadow_keys[0];
                res.tag    = shadow_tags[0];
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_keys[i-1] = shadow_keys[i];
                    shadow_tags[i-1] = shadow_tags[i];
                end
                shadow_count--;
            end
        end
        res.occupancy = CNT_W'(shadow_count);
        return res;
    endfunction

    // Send one item; the expectation is queued at the transfer
    task automatic send_item(t_mode mode, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
        int gap;
        gap = $urandom_range(src_gap_max, 0);
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= IN_DATA_W'({tag, key});
        do
            @(posedge i_clk);
        while (!s_tready);
        pending_results.push_back(queue_step(mode, key, tag));
    endtask

    task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, expected, actual);
            error_count++;
        end
    endtask

    // Result side: compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual status %0d tdata 0x%0h",
                         $time, m_tuser, m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("out_key", want.key, m_tdata[31:0]);
                check_field("out_tag", 32'(want.tag), 32'(m_tdata[47:32]));
                check_field("occupancy", 32'(want.occupancy), 32'(m_tdata[52:48]));
            end
            sink_hold = $urandom_range(sink_gap_max, 0);
        end
    end

    // Receiver may stall for a random hold after each transfer
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            m_tready <= 1'b0;
            sink_hold = sink_hold - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic test_pop_on_empty();
        send_item(MODE_POP, 32'hFFFF_FFFF, 16'hFFFF);
    endtask

    // Fill with extreme and scattered keys
    task automatic test_fill_extremes();
        send_item(MODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(MODE_INSERT, 32'h0000_0000, 16'h0000);
        send_item(MODE_INSERT, 32'h8000_0000, 16'h8000);
        send_item(MODE_INSERT, 32'h0000_0001, 16'h0001);
        send_item(MODE_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
        send_item(MODE_INSERT, 32'h0001_0000, 16'h1000);
        send_item(MODE_INSERT, 32'hFFFF_0000, 16'h5555);
        send_item(MODE_INSERT, 32'h0000_FFFF, 16'hAAAA);
        repeat (4) send_item(MODE_INSERT, $urandom(), 16'($urandom()));
    endtask

    // Same key as a stored entry: the newest must come out first
    task automatic test_equal_keys();
        for (int i = 0; i < 4; i++)
            send_item(MODE_INSERT, 32'h0001_0000, 16'hA000 + 16'(i));
    endtask

    task automatic test_insert_full();
        send_item(MODE_INSERT, 32'h0000_0000, 16'h1234);
    endtask

    task automatic test_pop_order();
        repeat (5) send_item(MODE_POP, $urandom(), 16'($urandom()));
    endtask

    // Phases with different insert/pop mixes sweep the queue between empty and full
    task automatic test_random_traffic();
        int sent;
        int phase_len;
        int insert_pct;
        bit narrow_keys;
        t_mode mode;
        logic [KEY_W-1:0] key;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(60, 15);
            case ($urandom_range(3, 0))
                0: begin
                    insert_pct = 20;
                end
                1: begin
                    insert_pct = 50;
                end
                2: begin
                    insert_pct = 80;
                end
                default: begin
                    insert_pct = 95;
                end
            endcase
            narrow_keys  = $urandom_range(1, 0);
            src_gap_max  = ($urandom_range(2, 0) == 0) ? 0 : 5;
            sink_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 5;
            repeat (phase_len) begin
                mode = ($urandom_range(99, 0) < insert_pct) ? MODE_INSERT : MODE_POP;
                if (narrow_keys) begin
                    // few distinct keys so ties are common
                    case ($urandom_range(3, 0))
                        0: begin
                            key = 32'h0000_0000;
                        end
                        1: begin
                            key = 32'h0001_0000;
                        end
                        2: begin
                            key = 32'h0001_8000;
                        end
                        default: begin
                            key = 32'hFFFF_FFFF;
                        end
                    endcase
                end else begin
                    key = $urandom();
                end
                send_item(mode, key, 16'($urandom()));
                sent++;
            end
        end
    endtask

    task automatic finish_run();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_pop_on_empty();
        test_fill_extremes();
        test_equal_keys();
        test_insert_full();
        test_pop_order();
        test_random_traffic();
        finish_run();
    end

endmodule

### sorted_insert_priority_queue.f
+incdir+rtl/core
rtl/core/sipq_pkg.sv
rtl/core/sipq_cell.sv
rtl/core/sorted_insert_priority_queue.sv
tb/sv/sorted_insert_priority_queue_tb.sv
